[sv/hem_pkg.sv]
// hem_pkg: shared types and constants for the haptic envelope mixer
// slot record layout, envelope phase codes and sequencer states; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hem_pkg;

  // default number of envelope slots owned by each motor
  localparam int unsigned SlotsPerMotor = 16;

  // envelope phase of one slot
  typedef enum logic [1:0] {
    PH_RISE = 2'd0,
    PH_HOLD = 2'd1,
    PH_FALL = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_WRITE  = 5'b00100,
    ST_TICK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic [15:0] rise;
    logic [15:0] peak;
    logic [16:0] mark;
    logic [15:0] fall;
    logic [15:0] remaining;
    phase_e      phase;
    logic [15:0] level;
  } entry_t;

endpackage

`default_nettype wire

[sv/haptic_envelope_mixer_core.sv]
// haptic_envelope_mixer_core: two-motor multi-slot envelope mixer around one slot memory
// depends on hem_pkg for the slot record, phase codes and sequencer states
//
// sequence: a camera start goes straight to the write state; another start first scans
// the motor's free-slot candidates, one read a cycle, up to the first idle one, then does
// one write; a running tick does one read-modify-write a cycle over all slots through the
// single memory read port, writing back active slots; a frozen tick goes to finish
// throughput: one word at a time; a result waits in the output register while the
// next word is taken
// reset: valid flags of all slots clear at once (no clearing pass), enable resets to 1
`timescale 1ns / 1ps
`default_nettype none

module haptic_envelope_mixer_core #(
  parameter int unsigned SLOTS_PER_MOTOR = hem_pkg::SlotsPerMotor
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic        motor_select_i,
  input  wire logic [15:0] rise_step_i,
  input  wire logic [15:0] peak_level_i,
  input  wire logic [15:0] sustain_ticks_i,
  input  wire logic [15:0] fall_step_i,
  input  wire logic [15:0] length_ticks_i,
  input  wire logic        camera_slot_i,
  input  wire logic        in_game_i,
  // result word channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      left_level_o,
  output logic [15:0]      right_level_o,
  // enable register write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  localparam int unsigned Total = 2 * SLOTS_PER_MOTOR;
  localparam int unsigned AW    = $clog2(Total);

  localparam logic [AW-1:0] LastSlot = AW'(Total - 1);

  // sequencer and word registers
  hem_pkg::state_e state_q, state_d;
  logic            en_q;
  logic [15:0]     rise_q, rise_d;
  logic [15:0]     peak_q, peak_d;
  logic [16:0]     mark_q, mark_d;
  logic [15:0]     fall_q, fall_d;
  logic [15:0]     len_q, len_d;
  logic [AW-1:0]   base_q, base_d;
  logic [AW-1:0]   sel_q, sel_d;
  logic [AW-1:0]   best_q, best_d;
  logic [15:0]     best_rem_q, best_rem_d;
  logic            iss_q, iss_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            p_vld_q, p_vld_d;
  logic [AW-1:0]   p_idx_q, p_idx_d;
  logic [15:0]     lmax_q, lmax_d;
  logic [15:0]     rmax_q, rmax_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     out_left_q, out_left_d;
  logic [15:0]     out_right_q, out_right_d;

  // slot memory and its ports
  hem_pkg::entry_t mem_q [Total];
  logic [Total-1:0] valid_q;
  hem_pkg::entry_t rd_data_q;
  logic             rd_ok_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    waddr;
  hem_pkg::entry_t  wdata;

  hem_pkg::entry_t ent;
  hem_pkg::entry_t adv;
  logic            in_acc;
  logic [AW-1:0]   scan_last;

  // envelope step intermediates
  logic [16:0]     sum;
  logic            rise_hit;
  logic [15:0]     fbase;
  logic [16:0]     diff;
  logic            fall_pos;
  logic            hold_wait;

  // scan compare intermediates
  logic            scan_first;
  logic            scan_take;
  logic [AW-1:0]   new_best;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != hem_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign left_level_o  = out_left_q;
  assign right_level_o = out_right_q;
  assign scan_last = base_q + AW'(SLOTS_PER_MOTOR - 1);

  // a never-written slot reads as all zero
  assign ent = rd_ok_q ? rd_data_q : '0;

  // one envelope step on the slot just read, all branches computed side by side
  always_comb begin
    sum       = {1'b0, ent.level} + {1'b0, ent.rise};
    rise_hit  = (sum >= {1'b0, ent.peak});
    fbase     = (ent.phase == hem_pkg::PH_RISE) ? ent.peak : ent.level;
    diff      = {1'b0, fbase} - {1'b0, ent.fall};
    fall_pos  = !diff[16] && (diff[15:0] != 16'd0);
    hold_wait = ({1'b0, ent.remaining} > ent.mark);
    adv           = ent;
    adv.remaining = ent.remaining - 16'd1;
    case (ent.phase) inside
      hem_pkg::PH_RISE: begin
        if (!rise_hit) begin
          adv.level = sum[15:0];
        end else if (hold_wait) begin
          adv.level = ent.peak;
          adv.phase = hem_pkg::PH_HOLD;
        end else if (fall_pos) begin
          adv.level = diff[15:0];
          adv.phase = hem_pkg::PH_FALL;
        end else begin
          adv.level = 16'd0;
          adv.phase = hem_pkg::PH_DONE;
        end
      end
      hem_pkg::PH_HOLD, hem_pkg::PH_FALL: begin
        if (ent.phase == hem_pkg::PH_HOLD && hold_wait) begin
          adv.level = ent.level;
        end else if (fall_pos) begin
          adv.level = diff[15:0];
          adv.phase = hem_pkg::PH_FALL;
        end else begin
          adv.level = 16'd0;
          adv.phase = hem_pkg::PH_DONE;
        end
      end
      default: begin
        adv.level = ent.level;
      end
    endcase
  end

  // slot choice: first idle slot, else strictly fewest ticks left
  assign scan_first = (p_idx_q == base_q + AW'(1));
  assign scan_take  = scan_first || (ent.remaining < best_rem_q);
  assign new_best   = scan_take ? p_idx_q : best_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    rise_d      = rise_q;
    peak_d      = peak_q;
    mark_d      = mark_q;
    fall_d      = fall_q;
    len_d       = len_q;
    base_d      = base_q;
    sel_d       = sel_q;
    best_d      = best_q;
    best_rem_d  = best_rem_q;
    iss_d       = iss_q;
    idx_d       = idx_q;
    p_idx_d     = p_idx_q;
    lmax_d      = lmax_q;
    rmax_d      = rmax_q;
    out_valid_d = out_valid_q;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    we          = 1'b0;
    waddr       = p_idx_q;
    wdata       = adv;

    // result word taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hem_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func_i) begin
            rise_d = rise_step_i;
            peak_d = peak_level_i;
            fall_d = fall_step_i;
            len_d  = length_ticks_i;
            mark_d = (length_ticks_i > sustain_ticks_i) ?
                     {1'b0, length_ticks_i - sustain_ticks_i} : 17'd0;
            base_d = motor_select_i ? AW'(SLOTS_PER_MOTOR) : '0;
            if (camera_slot_i) begin
              sel_d   = base_d;
              state_d = hem_pkg::ST_WRITE;
            end else begin
              idx_d   = base_d + AW'(1);
              iss_d   = 1'b1;
              state_d = hem_pkg::ST_SCAN;
            end
          end else if (en_q && in_game_i) begin
            idx_d   = '0;
            iss_d   = 1'b1;
            lmax_d  = 16'd0;
            rmax_d  = 16'd0;
            state_d = hem_pkg::ST_TICK;
          end else begin
            lmax_d  = 16'd0;
            rmax_d  = 16'd0;
            state_d = hem_pkg::ST_FINISH;
          end
        end
      end
      hem_pkg::ST_SCAN: begin
        rd_en = iss_q;
        if (p_vld_q) begin
          if (ent.remaining == 16'd0) begin
            sel_d   = p_idx_q;
            iss_d   = 1'b0;
            rd_en   = 1'b0;
            state_d = hem_pkg::ST_WRITE;
          end else begin
            best_d     = new_best;
            best_rem_d = scan_take ? ent.remaining : best_rem_q;
            if (p_idx_q == scan_last) begin
              sel_d   = new_best;
              state_d = hem_pkg::ST_WRITE;
            end
          end
        end
        if (rd_en) begin
          if (idx_q == scan_last) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      hem_pkg::ST_WRITE: begin
        we              = 1'b1;
        waddr           = sel_q;
        wdata.rise      = rise_q;
        wdata.peak      = peak_q;
        wdata.mark      = mark_q;
        wdata.fall      = fall_q;
        wdata.remaining = len_q;
        wdata.phase     = hem_pkg::PH_RISE;
        wdata.level     = 16'd0;
        state_d         = hem_pkg::ST_IDLE;
      end
      hem_pkg::ST_TICK: begin
        rd_en = iss_q;
        if (rd_en) begin
          if (idx_q == LastSlot) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
        if (p_vld_q) begin
          if (ent.remaining != 16'd0) begin
            we = 1'b1;
            if (p_idx_q >= AW'(SLOTS_PER_MOTOR)) begin
              if (adv.level > rmax_q) rmax_d = adv.level;
            end else begin
              if (adv.level > lmax_q) lmax_d = adv.level;
            end
          end
          if (p_idx_q == LastSlot) begin
            state_d = hem_pkg::ST_FINISH;
          end
        end
      end
      hem_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_left_d  = lmax_q;
          out_right_d = rmax_q;
          state_d     = hem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hem_pkg::ST_IDLE;
      end
    endcase

    // read pipeline tag follows the issued address
    p_vld_d = rd_en;
    if (rd_en) begin
      p_idx_d = rd_addr;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hem_pkg::ST_IDLE;
      en_q        <= 1'b1;
      iss_q       <= 1'b0;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rise_q      <= rise_d;
    peak_q      <= peak_d;
    mark_q      <= mark_d;
    fall_q      <= fall_d;
    len_q       <= len_d;
    base_q      <= base_d;
    sel_q       <= sel_d;
    best_q      <= best_d;
    best_rem_q  <= best_rem_d;
    idx_q       <= idx_d;
    p_idx_q     <= p_idx_d;
    lmax_q      <= lmax_d;
    rmax_q      <= rmax_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
  end

  // slot memory: one write and one registered read per cycle; the sequencer never reads
  // and writes the same slot in one cycle, since each slot is visited once per word
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_ok_q   <= valid_q[rd_addr];
    end
  end

`ifndef SYNTH
  // the memory is written only while a word is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q != hem_pkg::ST_IDLE))
    else $error("slot memory written while idle");

  // a new result word is loaded only from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == hem_pkg::ST_FINISH))
    else $error("result word appeared outside finish");

  // the free-slot scan never reads the reserved camera slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hem_pkg::ST_SCAN && rd_en) |-> (rd_addr != base_q))
    else $error("scan read the camera slot");

  // tick write-back only for slots that are active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hem_pkg::ST_TICK && we) |-> (p_vld_q && ent.remaining != 16'd0))
    else $error("tick wrote back an idle slot");

  // a start write leaves the tick read pipeline empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hem_pkg::ST_WRITE) |=> !p_vld_q)
    else $error("read still in flight after start write");
`endif

endmodule

`default_nettype wire

[dv/tb_haptic_envelope_mixer_core.sv]
// tb_haptic_envelope_mixer_core: self-checking bench for the two-motor envelope mixer
// depends on hem_pkg for phase codes and on haptic_envelope_mixer_core
// keeps its own slot table, predicts the drive levels of every tick word and checks them
`timescale 1ns / 1ps

module tb_haptic_envelope_mixer_core;

  localparam int SLOTS = hem_pkg::SlotsPerMotor;
  localparam int ALL_SLOTS = 2 * SLOTS;
  localparam int LEVEL_MAX = 'hFFFF;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 40;
  localparam int DIRECTED_ROWS = 23;

  // word kinds on the input channel
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  localparam logic MOTOR_LEFT = 1'b0;
  localparam logic MOTOR_RIGHT = 1'b1;

  typedef struct packed {
    op_e         op;
    logic        motor;
    logic [15:0] rise;
    logic [15:0] peak;
    logic [15:0] sus;
    logic [15:0] fall;
    logic [15:0] len;
    logic        camera;
    logic        in_game;
  } hap_word_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } levels_t;

  typedef struct packed {
    hap_word_t w;
    logic      typed;
    levels_t   want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hap_word_t drive_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  logic [15:0] left_level;
  logic [15:0] right_level;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // predicted slot table and enable register
  logic [15:0] slot_rise [ALL_SLOTS];
  logic [15:0] slot_peak [ALL_SLOTS];
  logic [16:0] slot_mark [ALL_SLOTS];
  logic [15:0] slot_fall [ALL_SLOTS];
  logic [15:0] slot_remain [ALL_SLOTS];
  hem_pkg::phase_e slot_phase [ALL_SLOTS];
  logic [15:0] slot_level [ALL_SLOTS];
  bit          enable_q = 1'b1;

  levels_t   pending_levels_q[$];
  levels_t   got_want;
  stim_row_t directed_rows [DIRECTED_ROWS];

  int sender_idle_pct = 37;
  int receiver_stall_pct = 75;
  bit want_hold = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int error_cnt = 0;
  int start_cnt = 0;
  int tick_cnt = 0;
  int checked_cnt = 0;
  int cycle_cnt = 0;

  haptic_envelope_mixer_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (drive_word.op),
    .motor_select_i (drive_word.motor),
    .rise_step_i    (drive_word.rise),
    .peak_level_i   (drive_word.peak),
    .sustain_ticks_i(drive_word.sus),
    .fall_step_i    (drive_word.fall),
    .length_ticks_i (drive_word.len),
    .camera_slot_i  (drive_word.camera),
    .in_game_i      (drive_word.in_game),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_level_o   (left_level),
    .right_level_o  (right_level),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("haptic_envelope_mixer_core regression: fail");
      $finish;
    end
  end

  task automatic report_error(string msg);
    error_cnt++;
    if (error_cnt <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // envelope prediction: updates the slot table, returns 1 when the word yields drive levels
  function automatic bit predict_envelope_word(input hap_word_t w, output levels_t res);
    int unsigned base;
    int unsigned pick;
    int unsigned s;
    int lv;
    hem_pkg::phase_e ph;
    res = '0;
    if (w.op == OP_START) begin
      base = w.motor ? SLOTS : 0;
      pick = 1;
      if (w.camera) begin
        pick = 0;
      end else begin
        // first idle slot, else the lowest slot with the fewest ticks left
        for (int unsigned i = 1; i < SLOTS; i++) begin
          if (slot_remain[base + i] == 0) begin
            pick = i;
            break;
          end
          if (slot_remain[base + i] < slot_remain[base + pick]) pick = i;
        end
      end
      s = base + pick;
      slot_rise[s] = w.rise;
      slot_peak[s] = w.peak;
      slot_mark[s] = (w.len > w.sus) ? 17'(w.len - w.sus) : '0;
      slot_fall[s] = w.fall;
      slot_remain[s] = w.len;
      slot_phase[s] = hem_pkg::PH_RISE;
      slot_level[s] = '0;
      return 1'b0;
    end
    // frozen tick: nothing moves, motors read zero
    if (!(enable_q && w.in_game)) return 1'b1;
    for (int unsigned k = 0; k < ALL_SLOTS; k++) begin
      if (slot_remain[k] == 0) continue;
      lv = int'(slot_level[k]);
      ph = slot_phase[k];
      if (ph == hem_pkg::PH_RISE) begin
        lv += int'(slot_rise[k]);
        if (lv >= int'(slot_peak[k])) begin
          lv = int'(slot_peak[k]);
          ph = hem_pkg::PH_HOLD;
        end
      end
      if (ph == hem_pkg::PH_HOLD && slot_remain[k] <= slot_mark[k]) ph = hem_pkg::PH_FALL;
      if (ph == hem_pkg::PH_FALL) begin
        lv -= int'(slot_fall[k]);
        if (lv <= 0) begin
          lv = 0;
          ph = hem_pkg::PH_DONE;
        end
      end
      if (lv < 0) lv = 0;
      if (lv > LEVEL_MAX) lv = LEVEL_MAX;
      slot_level[k] = 16'(lv);
      slot_phase[k] = ph;
      slot_remain[k] = slot_remain[k] - 16'd1;
      if (k < SLOTS) begin
        if (slot_level[k] > res.left) res.left = slot_level[k];
      end else begin
        if (slot_level[k] > res.right) res.right = slot_level[k];
      end
    end
    return 1'b1;
  endfunction

  // offer one word, idling per cycle at random, hold it until taken
  task automatic put_word(hap_word_t w, bit typed, levels_t typed_levels);
    levels_t pred;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drive_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.op == OP_START) start_cnt++;
    else tick_cnt++;
    if (predict_envelope_word(w, pred)) pending_levels_q.push_back(typed ? typed_levels : pred);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(7)) inside
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(16'h1000, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic hap_word_t random_word();
    hap_word_t w;
    w.op = ($urandom_range(99) < 45) ? OP_START : OP_TICK;
    w.motor = 1'($urandom_range(1));
    w.camera = ($urandom_range(99) < 12);
    w.rise = pick_level();
    w.peak = pick_level();
    w.fall = pick_level();
    w.sus = ($urandom_range(1)) ? 16'($urandom_range(50)) : 16'($urandom);
    // long envelopes go to the camera slot so that the other slots keep turning over
    if (w.camera && $urandom_range(1)) w.len = 16'($urandom);
    else w.len = 16'($urandom_range(40));
    w.in_game = ($urandom_range(99) < 90);
    return w;
  endfunction

  // random words with occasional bursts of short starts that fill one motor
  task automatic run_random(int count);
    hap_word_t w;
    int burst_left = 0;
    logic burst_motor = MOTOR_LEFT;
    for (int n = 0; n < count; n++) begin
      w = random_word();
      if (burst_left == 0 && $urandom_range(99) < 3) begin
        burst_left = $urandom_range(20, 12);
        burst_motor = 1'($urandom_range(1));
      end
      if (burst_left > 0) begin
        w.op = OP_START;
        w.motor = burst_motor;
        w.camera = 1'b0;
        w.len = 16'($urandom_range(6, 1));
        burst_left--;
      end
      put_word(w, 1'b0, '0);
    end
  endtask

  // drop valid, let every expected word arrive, then let the block settle
  task automatic wait_quiet();
    int waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    enable_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (want_hold && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels_q.size() == 0) begin
        report_error($sformatf("unexpected word left=%h right=%h", left_level, right_level));
      end else begin
        got_want = pending_levels_q.pop_front();
        checked_cnt++;
        if (left_level !== got_want.left)
          report_error($sformatf("left_level %h, expected %h", left_level, got_want.left));
        if (right_level !== got_want.right)
          report_error($sformatf("right_level %h, expected %h", right_level, got_want.right));
      end
    end
  end

  initial begin
    for (int i = 0; i < ALL_SLOTS; i++) begin
      slot_rise[i] = '0;
      slot_peak[i] = '0;
      slot_mark[i] = '0;
      slot_fall[i] = '0;
      slot_remain[i] = '0;
      slot_phase[i] = hem_pkg::PH_RISE;
      slot_level[i] = '0;
    end
    // op, motor, rise, peak, sustain, fall, length, camera, in_game | typed, left, right
    directed_rows = '{
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b1, '{16'h0000, 16'h0000}},
      '{'{OP_START, MOTOR_LEFT, 16'h1000, 16'h3000, 16'h2, 16'h0800, 16'h8, 1'b1, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 1'b1, 1'b0},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b1, '{16'h1000, 16'hFFFF}},
      '{'{OP_TICK, MOTOR_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
        1'b1, '{16'h0000, 16'h0000}},
      '{'{OP_START, MOTOR_LEFT, 16'h8000, 16'hFFFF, 16'h0, 16'hFFFF, 16'h4, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_LEFT, 16'h4000, 16'h9000, 16'h64, 16'h0100, 16'h5, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_RIGHT, 16'h1234, 16'h5678, 16'h3, 16'h0010, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_RIGHT, 16'h0, 16'h0, 16'h1, 16'h0, 16'h3, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_RIGHT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1, 1'b1, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0},
        1'b1, '{16'h0000, 16'h0000}},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_START, MOTOR_LEFT, 16'hFFFF, 16'h0001, 16'h0, 16'h0001, 16'h2, 1'b0, 1'b0},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b0, '0},
      // every envelope has run out by now
      '{'{OP_TICK, MOTOR_LEFT, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1},
        1'b1, '{16'h0000, 16'h0000}}
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed words, sender idles 37 percent, receiver stalls 75 percent
    for (int r = 0; r < DIRECTED_ROWS; r++)
      put_word(directed_rows[r].w, directed_rows[r].typed, directed_rows[r].want);
    wait_quiet();

    // vibration disabled: starts load, ticks read zero
    write_enable(1'b0);
    run_random(200);
    wait_quiet();

    // enabled again, idling reversed
    write_enable(1'b1);
    sender_idle_pct = 75;
    receiver_stall_pct = 37;
    run_random(900);
    wait_quiet();

    // no idling, with one long receiver hold-off to back the block up
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    want_hold = 1'b1;
    run_random(900);
    wait_quiet();

    if (pending_levels_q.size() != 0)
      report_error($sformatf("%0d expected words never arrived", pending_levels_q.size()));
    $display("covered %0d start words and %0d tick words, %0d drive words checked",
             start_cnt, tick_cnt, checked_cnt);
    $display("enable off and on, slot reuse under full motors, long output hold-off; %0d errors",
             error_cnt);
    if (error_cnt == 0) begin
      $display("haptic_envelope_mixer_core regression: pass");
    end else begin
      $display("haptic_envelope_mixer_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/hem_pkg.sv
sv/haptic_envelope_mixer_core.sv
dv/tb_haptic_envelope_mixer_core.sv
